// ===== rtl/sme_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the signed modular exponentiation block.
// No dependencies.
package sme_pkg;

	// Widths fixed by the interface.
	localparam int CFG_W     = 32;  // configuration data width
	localparam int MSG_W     = 33;  // signed message and result width
	localparam int CFG_IDX_W = 1;   // register index width

	// Default operand width.
	localparam int DATA_BITS_DEF = 32;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

endpackage

// ===== rtl/signed_modular_exponentiation.sv =====
`timescale 1ns / 1ps
// Signed modular exponentiation by right-to-left square-and-multiply.
// Depends on sme_pkg.
//
// Usage:
// - Configuration: write the exponent (index REG_EXPONENT) and the modulus
//   (index REG_MODULUS) through cfg_we / cfg_index / cfg_data while idle.
//   Only the low DATA_BITS bits of each are used. Reset gives exponent 1,
//   modulus 2.
// - Input: an item is taken at a rising edge with start high and busy low.
//   busy stays high until the result is out; start is ignored meanwhile.
// - Output: done pulses for one cycle with result valid in that cycle.
//   The receiver cannot stall; a result not taken in that cycle is gone.
// - Datapath: one shared multiplier and one shift-subtract reducer do all
//   the work. Every reduction walks RW = max(2*DATA_BITS, 33) dividend bits,
//   one bit a cycle. The base is reduced first; each exponent bit up to its
//   highest set bit then takes a step state, for a set bit a multiply of acc
//   by sq with its reduction, and a square with its reduction; the square
//   after the highest set bit is skipped. A modulus below 2 raises done in
//   the cycle right after start.
// - Reset clears the sequencer and the strobe; the block comes up idle.
// - The result strobe may coincide with a new start, since busy is already
//   low in that cycle.
module signed_modular_exponentiation #(
	parameter int DATA_BITS = sme_pkg::DATA_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [sme_pkg::MSG_W-1:0]   message,
	output logic                               done,
	output logic signed [sme_pkg::MSG_W-1:0]   result,
	input  logic                               cfg_we,
	input  logic        [sme_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [sme_pkg::CFG_W-1:0]   cfg_data
);
	import sme_pkg::*;

	localparam int DW    = DATA_BITS;
	localparam int PW    = 2 * DATA_BITS;
	localparam int RW    = (PW > MSG_W) ? PW : MSG_W;
	localparam int CNT_W = $clog2(RW);

	typedef enum logic [1:0] {ST_IDLE, ST_STEP, ST_MUL, ST_RED} state_t;
	typedef enum logic [1:0] {PH_BASE, PH_ACC, PH_SQR} phase_t;

	state_t            state_q;
	phase_t            phase_q;
	logic [DW-1:0]     exp_cfg_q;
	logic [DW-1:0]     mod_cfg_q;
	logic [DW-1:0]     mod_q;
	logic [DW-1:0]     exp_q;
	logic [DW-1:0]     acc_q;
	logic [DW-1:0]     sq_q;
	logic [DW-1:0]     rem_q;
	logic [RW-1:0]     div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;

	logic [MSG_W-1:0]  mag_w;
	logic [DW-1:0]     mul_a;
	logic [PW-1:0]     prod_w;
	logic [DW:0]       rem_shift;
	logic [DW:0]       rem_sub;
	logic [DW-1:0]     rem_next;

	// Magnitude of the message; the pattern -2^32 gives 2^32.
	assign mag_w = message[MSG_W-1] ? (MSG_W'(0) - MSG_W'(message)) : MSG_W'(message);

	// Shared multiplier: acc * sq in the accumulate phase, else sq * sq.
	assign mul_a  = (phase_q == PH_ACC) ? acc_q : sq_q;
	assign prod_w = PW'(mul_a) * PW'(sq_q);

	// Shift-subtract reducer: bring in one dividend bit, subtract if it fits.
	assign rem_shift = {rem_q, div_q[RW-1]};
	assign rem_sub   = rem_shift - {1'b0, mod_q};
	assign rem_next  = (rem_shift >= {1'b0, mod_q}) ? rem_sub[DW-1:0] : rem_shift[DW-1:0];

	assign busy = (state_q != ST_IDLE);

	// Apply the sign of the message; a zero power stays zero.
	function automatic logic [MSG_W-1:0] apply_sign(input logic neg, input logic [DW-1:0] p);
		logic [MSG_W-1:0] pe;
		pe = MSG_W'(p);
		return neg ? (MSG_W'(0) - pe) : pe;
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cfg_q <= DW'(1);
			mod_cfg_q <= DW'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPONENT: exp_cfg_q <= cfg_data[DW-1:0];
				REG_MODULUS:  mod_cfg_q <= cfg_data[DW-1:0];
				default:      ;
			endcase
		end
	end

	// Sequencer, datapath registers and result outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_BASE;
			done    <= 1'b0;
			result  <= '0;
			neg_q   <= 1'b0;
			exp_q   <= '0;
			mod_q   <= '0;
			acc_q   <= '0;
			sq_q    <= '0;
			rem_q   <= '0;
			div_q   <= '0;
			cnt_q   <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						neg_q <= message[MSG_W-1];
						exp_q <= exp_cfg_q;
						mod_q <= mod_cfg_q;
						acc_q <= DW'(1);
						if (mod_cfg_q < DW'(2)) begin
							// Degenerate modulus: every power is zero.
							result  <= MSG_W'(0);
							done    <= 1'b1;
						end else begin
							// Reduce the base first.
							div_q   <= RW'(mag_w);
							rem_q   <= '0;
							cnt_q   <= CNT_W'(RW - 1);
							phase_q <= PH_BASE;
							state_q <= ST_RED;
						end
					end
				end
				ST_STEP: begin
					priority if (exp_q == '0) begin
						// No set bits left: acc holds the power.
						result  <= apply_sign(neg_q, acc_q);
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else if (exp_q[0]) begin
						phase_q <= PH_ACC;
						state_q <= ST_MUL;
					end else begin
						phase_q <= PH_SQR;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// Register the product as the next dividend.
					div_q   <= RW'(prod_w);
					rem_q   <= '0;
					cnt_q   <= CNT_W'(RW - 1);
					state_q <= ST_RED;
				end
				ST_RED: begin
					rem_q <= rem_next;
					div_q <= {div_q[RW-2:0], 1'b0};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						unique case (phase_q)
							PH_BASE: begin
								sq_q    <= rem_next;
								state_q <= ST_STEP;
							end
							PH_ACC: begin
								acc_q <= rem_next;
								if (exp_q[DW-1:1] == '0) begin
									// Last set bit: skip the unused square.
									result  <= apply_sign(neg_q, rem_next);
									done    <= 1'b1;
									state_q <= ST_IDLE;
								end else begin
									phase_q <= PH_SQR;
									state_q <= ST_MUL;
								end
							end
							PH_SQR: begin
								sq_q    <= rem_next;
								exp_q   <= exp_q >> 1;
								state_q <= ST_STEP;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
